### rtl/sle_pkg.sv
package sle_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int DATA_W       = 32;
    localparam int FUNC_W       = 2;
    localparam int STATUS_W     = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT    = 2'd0,
        FUNC_DELETE    = 2'd1,
        FUNC_DUMP_UP   = 2'd2,
        FUNC_DUMP_DOWN = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_DUMP = 1'b1
    } state_t;

    // what every cell does in a given cycle
    typedef enum logic [2:0] {
        CELL_HOLD   = 3'd0,
        CELL_INS    = 3'd1,
        CELL_DEL    = 3'd2,
        CELL_ROT_UP = 3'd3,
        CELL_ROT_DN = 3'd4
    } cell_op_t;

    typedef struct packed {
        cell_op_t                  op;
        logic signed [DATA_W-1:0]  key;
    } cell_ctrl_t;

endpackage

### rtl/sorted_list_engine_unit.sv
// Insert / delete: result beat registered, valid in the cycle after the input beat; one item
//   per cycle while the output is taken (compare and shift happen in all cells at once).
// Dump of N values: N result beats from the dump state, one per cycle while the output
//   is taken; no new input is taken until the last beat is loaded (chain rotates once).
// Reset (rst_n low, async): count cleared, store empty, output empty. Entry data
//   is not cleared; only cells below the count are ever read.
module sorted_list_engine_unit #(
    parameter int CAPACITY = sle_pkg::CAPACITY_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sle_pkg::DATA_W-1:0]    s_tdata,   // [31:0] item_value
    input  logic [sle_pkg::FUNC_W-1:0]    s_tuser,   // [1:0] func
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sle_pkg::DATA_W-1:0]    m_tdata,   // [31:0] out_value
    output logic [sle_pkg::STATUS_W-1:0]  m_tuser,   // [1:0] status
    output logic                          m_tlast    // last
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int DW    = sle_pkg::DATA_W;

    // store occupancy and dump progress
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [CNT_W-1:0]     rem_reg, rem_next;
    logic                 dir_reg, dir_next;      // 1: descending dump
    sle_pkg::state_t      state_reg, state_next;

    // output register
    logic                 mv_reg, mv_next;
    logic [DW-1:0]        md_reg, md_next;
    sle_pkg::status_t     mu_reg, mu_next;
    logic                 ml_reg, ml_next;

    // chain signals
    sle_pkg::cell_ctrl_t      ctrl;
    logic signed [DW-1:0]     cdata [CAPACITY];
    logic [CAPACITY-1:0]      occ;
    logic [CAPACITY-1:0]      take;
    logic [CAPACITY-1:0]      shift;
    logic [CAPACITY-1:0]      is_tail;
    logic [DW-1:0]            tail_and [CAPACITY];
    logic signed [DW-1:0]     head;
    logic signed [DW-1:0]     tail;

    logic                 out_free;
    logic                 full;
    logic                 empty;
    logic                 found;

    // occupancy is a thermometer of the count; cell i is the tail when i+1 is free
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_occ
            assign occ[gi] = cnt_reg > CNT_W'(gi);
            if (gi == CAPACITY - 1)
            begin : g_end
                assign is_tail[gi] = occ[gi];
            end
            else
            begin : g_mid
                assign is_tail[gi] = occ[gi] && !occ[gi+1];
            end
            assign tail_and[gi] = is_tail[gi] ? cdata[gi] : '0;
        end
    endgenerate

    // one-hot AND-OR select of the tail value
    always_comb
    begin
        tail = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            tail = tail | tail_and[i];
        end
    end

    assign head  = cdata[0];
    assign full  = (cnt_reg == CNT_W'(CAPACITY));
    assign empty = (cnt_reg == '0);
    assign found = shift[CAPACITY-1];

    // the cell chain
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic signed [DW-1:0] left_d;
            logic signed [DW-1:0] right_d;
            logic                 take_l;
            logic                 shift_l;
            logic                 occ_r;
            if (gi == 0)
            begin : g_first
                assign left_d  = tail;
                assign take_l  = 1'b0;
                assign shift_l = 1'b0;
            end
            else
            begin : g_inner
                assign left_d  = cdata[gi-1];
                assign take_l  = take[gi-1];
                assign shift_l = shift[gi-1];
            end
            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_d = '0;
                assign occ_r   = 1'b0;
            end
            else
            begin : g_notlast
                assign right_d = cdata[gi+1];
                assign occ_r   = occ[gi+1];
            end

            sle_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .occ        (occ[gi]),
                .occ_next   (occ_r),
                .left_data  (left_d),
                .right_data (right_d),
                .wrap_data  (head),
                .take_left  (take_l),
                .shift_in   (shift_l),
                .data       (cdata[gi]),
                .take       (take[gi]),
                .shift_out  (shift[gi])
            );
        end
    endgenerate

    assign out_free = !mv_reg || m_tready;

    // control: next state, chain op, output beat
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        dir_next   = dir_reg;
        ctrl.op    = sle_pkg::CELL_HOLD;
        ctrl.key   = $signed(s_tdata);
        s_tready   = 1'b0;
        mv_next    = mv_reg && !m_tready;
        md_next    = md_reg;
        mu_next    = mu_reg;
        ml_next    = ml_reg;

        case (state_reg)
            sle_pkg::S_IDLE:
            begin
                s_tready = out_free;
                if (s_tvalid && out_free)
                begin
                    mv_next = 1'b1;
                    md_next = '0;
                    ml_next = 1'b1;
                    mu_next = sle_pkg::ST_OK;
                    case (sle_pkg::func_t'(s_tuser))
                        sle_pkg::FUNC_INSERT:
                        begin
                            if (full)
                            begin
                                mu_next = sle_pkg::ST_FULL;
                            end
                            else
                            begin
                                ctrl.op  = sle_pkg::CELL_INS;
                                cnt_next = cnt_reg + CNT_W'(1);
                            end
                        end
                        sle_pkg::FUNC_DELETE:
                        begin
                            // a miss shifts no cell, so the op is harmless
                            ctrl.op = sle_pkg::CELL_DEL;
                            if (found)
                            begin
                                cnt_next = cnt_reg - CNT_W'(1);
                            end
                            else
                            begin
                                mu_next = sle_pkg::ST_NOT_FOUND;
                            end
                        end
                        default:
                        begin
                            if (empty)
                            begin
                                mu_next = sle_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                // results come from the dump state
                                mv_next    = mv_reg && !m_tready;
                                md_next    = md_reg;
                                mu_next    = mu_reg;
                                ml_next    = ml_reg;
                                state_next = sle_pkg::S_DUMP;
                                rem_next   = cnt_reg;
                                dir_next   = (sle_pkg::func_t'(s_tuser) ==
                                              sle_pkg::FUNC_DUMP_DOWN);
                            end
                        end
                    endcase
                end
            end
            sle_pkg::S_DUMP:
            begin
                if (out_free)
                begin
                    // rotate the list one place; after cnt beats it is back in order
                    ctrl.op  = dir_reg ? sle_pkg::CELL_ROT_DN : sle_pkg::CELL_ROT_UP;
                    mv_next  = 1'b1;
                    md_next  = dir_reg ? tail : head;
                    mu_next  = sle_pkg::ST_OK;
                    ml_next  = (rem_reg == CNT_W'(1));
                    rem_next = rem_reg - CNT_W'(1);
                    if (rem_reg == CNT_W'(1))
                    begin
                        state_next = sle_pkg::S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = sle_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sle_pkg::S_IDLE;
            cnt_reg   <= '0;
            rem_reg   <= '0;
            dir_reg   <= 1'b0;
            mv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            rem_reg   <= rem_next;
            dir_reg   <= dir_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        md_reg <= md_next;
        mu_reg <= mu_next;
        ml_reg <= ml_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tuser  = mu_reg;
    assign m_tlast  = ml_reg;

    // count stays within the chain
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // no input beat while a dump is running
    a_no_accept_dump: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == sle_pkg::S_DUMP |-> !s_tready)
        else $error("input accepted during dump");

    // a successful insert grows the store by one
    a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == sle_pkg::FUNC_INSERT && !full)
        |=> cnt_reg == $past(cnt_reg) + CNT_W'(1))
        else $error("insert did not grow count");

    // dump stays live for exactly the remaining count
    a_dump_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sle_pkg::S_DUMP && out_free && rem_reg == CNT_W'(1))
        |=> state_reg == sle_pkg::S_IDLE && m_tvalid && m_tlast)
        else $error("dump did not close with last beat");

    // every status beat is a single-beat result
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != sle_pkg::ST_OK) |-> m_tlast)
        else $error("status beat without last");

endmodule

### rtl/sle_cell.sv
module sle_cell (
    input  logic                              clk,
    input  sle_pkg::cell_ctrl_t               ctrl,
    input  logic                              occ,        // this cell holds a value
    input  logic                              occ_next,   // right neighbor holds a value
    input  logic signed [sle_pkg::DATA_W-1:0] left_data,  // cell 0: tail of the list
    input  logic signed [sle_pkg::DATA_W-1:0] right_data,
    input  logic signed [sle_pkg::DATA_W-1:0] wrap_data,  // head of the list
    input  logic                              take_left,
    input  logic                              shift_in,
    output logic signed [sle_pkg::DATA_W-1:0] data,
    output logic                              take,
    output logic                              shift_out
);

    logic signed [sle_pkg::DATA_W-1:0] data_reg;
    logic signed [sle_pkg::DATA_W-1:0] data_next;

    // insert point: first free cell or first value >= key
    assign take      = !occ || (data_reg >= ctrl.key);
    // delete: everything from the first match onward pulls from the right
    assign shift_out = shift_in || (occ && (data_reg == ctrl.key));
    assign data      = data_reg;

    always_comb
    begin
        data_next = data_reg;
        case (ctrl.op)
            sle_pkg::CELL_INS:
            begin
                if (take)
                begin
                    data_next = take_left ? left_data : ctrl.key;
                end
            end
            sle_pkg::CELL_DEL:
            begin
                if (shift_out)
                begin
                    data_next = right_data;
                end
            end
            sle_pkg::CELL_ROT_UP:
            begin
                if (occ)
                begin
                    data_next = occ_next ? right_data : wrap_data;
                end
            end
            sle_pkg::CELL_ROT_DN:
            begin
                if (occ)
                begin
                    data_next = left_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule
